// ===== src/rgb_to_hsv_converter_defines.svh =====
// Assertion macros shared by the RGB to HSV converter.
// Depends on nothing; the asserting module must have i_clk and i_rst_n in scope.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RGBHSV_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RGBHSV_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rgbhsv_pkg.sv =====
// Shared types, constants and helper functions for the RGB to HSV converter.
// Depends on nothing; used by every module of the block.
package rgbhsv_pkg;

    // Default parameter values of the top level.
    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SAT_BITS_DEF      = 16;

    // Hue covers 0 to 359 degrees, so nine integer bits.
    localparam int HUE_INT_BITS = 9;
    localparam int HUE_FULL_DEG = 360;

    // Sector offsets in degrees and the width of one sector.
    localparam int HUE_OFF_RED   = 0;
    localparam int HUE_OFF_GREEN = 120;
    localparam int HUE_OFF_BLUE  = 240;
    localparam int SECTOR_DEG    = 60;

    // Which channel holds the maximum.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Number of quotient bits, and so of divider stages, for the given format.
    function automatic int div_stage_count(input int hue_frac_bits, input int sat_bits);
        return max_int(HUE_INT_BITS + hue_frac_bits, sat_bits + 1);
    endfunction

endpackage

// ===== src/rgbhsv_front.sv =====
// Front end of the RGB to HSV converter: max/min search, sector choice and
// the two dividends. Two register stages. Depends on rgbhsv_pkg.
module rgbhsv_front #(
    parameter int CHANNEL_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_BITS      = rgbhsv_pkg::SAT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CHANNEL_BITS-1:0] o_hi,
    output logic [CHANNEL_BITS-1:0] o_d,
    output logic [CHANNEL_BITS+rgbhsv_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] o_hrem,
    output logic [CHANNEL_BITS+SAT_BITS-1:0] o_srem
);

    localparam int C   = CHANNEL_BITS;
    localparam int TW  = C + rgbhsv_pkg::HUE_INT_BITS;
    localparam int HNW = TW + HUE_FRAC_BITS;
    localparam int SNW = C + SAT_BITS;

    // Stage one registers.
    logic                 r1_valid;
    logic [C-1:0]         r1_hi;
    logic [C-1:0]         r1_lo;
    rgbhsv_pkg::t_sector  r1_sec;
    logic                 r1_wrap;
    logic signed [C:0]    r1_num;
    logic [C-1:0]         n1_hi;
    logic [C-1:0]         n1_lo;
    rgbhsv_pkg::t_sector  n1_sec;
    logic                 n1_wrap;
    logic signed [C:0]    n1_num;
    logic                 w1_ready;

    // Stage two registers.
    logic                 r2_valid;
    logic [C-1:0]         r2_hi;
    logic [C-1:0]         r2_d;
    logic [HNW-1:0]       r2_hrem;
    logic [SNW-1:0]       r2_srem;
    logic [C-1:0]         n2_d;
    logic [HNW-1:0]       n2_hrem;
    logic [SNW-1:0]       n2_srem;
    logic                 w2_ready;
    logic [rgbhsv_pkg::HUE_INT_BITS-1:0] w_off;
    logic [TW-1:0]        w_num_x;
    logic [TW-1:0]        w_total;

    // A stage takes a new request when it is empty or its content moves on.
    assign w2_ready = !r2_valid || i_ready;
    assign w1_ready = !r1_valid || w2_ready;
    assign o_ready  = w1_ready;

    // Stage one: find the largest and smallest channel and the hue numerator.
    // Red wins ties over green, and green over blue.
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n1_sec = rgbhsv_pkg::SEC_RED;
            n1_hi  = i_red;
            n1_num = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n1_sec = rgbhsv_pkg::SEC_GREEN;
            n1_hi  = i_green;
            n1_num = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n1_sec = rgbhsv_pkg::SEC_BLUE;
            n1_hi  = i_blue;
            n1_num = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        n1_lo = i_red;
        if (i_green < n1_lo) begin
            n1_lo = i_green;
        end
        if (i_blue < n1_lo) begin
            n1_lo = i_blue;
        end
        // Red sector with a negative numerator wraps around to 360 degrees.
        n1_wrap = (n1_sec == rgbhsv_pkg::SEC_RED) && (i_green < i_blue);
    end

    // Stage two: sector offset and the two dividends.
    // The hue total is never negative and stays below 360 * 2^C, so
    // modular arithmetic at TW bits gives the exact value.
    always_comb begin
        unique case (r1_sec)
            rgbhsv_pkg::SEC_RED: begin
                w_off = r1_wrap ? rgbhsv_pkg::HUE_INT_BITS'(rgbhsv_pkg::HUE_FULL_DEG)
                                : rgbhsv_pkg::HUE_INT_BITS'(rgbhsv_pkg::HUE_OFF_RED);
            end
            rgbhsv_pkg::SEC_GREEN: w_off = rgbhsv_pkg::HUE_INT_BITS'(rgbhsv_pkg::HUE_OFF_GREEN);
            rgbhsv_pkg::SEC_BLUE:  w_off = rgbhsv_pkg::HUE_INT_BITS'(rgbhsv_pkg::HUE_OFF_BLUE);
            default:               w_off = rgbhsv_pkg::HUE_INT_BITS'(rgbhsv_pkg::HUE_OFF_RED);
        endcase
        n2_d    = r1_hi - r1_lo;
        w_num_x = {{(TW - C - 1){r1_num[C]}}, r1_num};
        w_total = TW'(w_off) * TW'(n2_d) + w_num_x * TW'(rgbhsv_pkg::SECTOR_DEG);
        n2_hrem = HNW'(w_total) << HUE_FRAC_BITS;
        n2_srem = SNW'(n2_d) << SAT_BITS;
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (w1_ready) begin
                r1_valid <= i_valid;
            end
            if (w2_ready) begin
                r2_valid <= r1_valid;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (w1_ready) begin
            r1_hi   <= n1_hi;
            r1_lo   <= n1_lo;
            r1_sec  <= n1_sec;
            r1_wrap <= n1_wrap;
            r1_num  <= n1_num;
        end
        if (w2_ready) begin
            r2_hi   <= r1_hi;
            r2_d    <= n2_d;
            r2_hrem <= n2_hrem;
            r2_srem <= n2_srem;
        end
    end

    assign o_valid = r2_valid;
    assign o_hi    = r2_hi;
    assign o_d     = r2_d;
    assign o_hrem  = r2_hrem;
    assign o_srem  = r2_srem;

endmodule

// ===== src/rgbhsv_div_stage.sv =====
// One restoring division step for both the hue and the saturation quotient,
// with its own register stage and handshake. Depends on rgbhsv_pkg.
module rgbhsv_div_stage #(
    parameter int CHANNEL_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_BITS      = rgbhsv_pkg::SAT_BITS_DEF,
    parameter int BIT_POS       = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CHANNEL_BITS-1:0] i_hi,
    input  logic [CHANNEL_BITS-1:0] i_d,
    input  logic [CHANNEL_BITS+rgbhsv_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] i_hrem,
    input  logic [rgbhsv_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] i_hquo,
    input  logic [CHANNEL_BITS+SAT_BITS-1:0] i_srem,
    input  logic [SAT_BITS:0]       i_squo,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CHANNEL_BITS-1:0] o_hi,
    output logic [CHANNEL_BITS-1:0] o_d,
    output logic [CHANNEL_BITS+rgbhsv_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] o_hrem,
    output logic [rgbhsv_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] o_hquo,
    output logic [CHANNEL_BITS+SAT_BITS-1:0] o_srem,
    output logic [SAT_BITS:0]       o_squo
);

    localparam int C   = CHANNEL_BITS;
    localparam int HQB = rgbhsv_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
    localparam int SQB = SAT_BITS + 1;
    localparam int HNW = C + HQB;
    localparam int SNW = C + SAT_BITS;
    localparam int CW  = C + rgbhsv_pkg::div_stage_count(HUE_FRAC_BITS, SAT_BITS);
    localparam bit HUE_ACT = (BIT_POS < HQB);
    localparam bit SAT_ACT = (BIT_POS < SQB);

    logic           r_valid;
    logic [C-1:0]   r_hi;
    logic [C-1:0]   r_d;
    logic [HNW-1:0] r_hrem;
    logic [HQB-1:0] r_hquo;
    logic [SNW-1:0] r_srem;
    logic [SQB-1:0] r_squo;
    logic [HNW-1:0] n_hrem;
    logic [HQB-1:0] n_hquo;
    logic [SNW-1:0] n_srem;
    logic [SQB-1:0] n_squo;
    logic [CW-1:0]  w_hden;
    logic [CW-1:0]  w_sden;
    logic           w_htake;
    logic           w_stake;

    assign o_ready = !r_valid || i_ready;

    // Compare the partial remainder with the divisor shifted to this bit and
    // subtract when it fits. The hue divides by max-min, saturation by max.
    always_comb begin
        w_hden  = CW'(i_d) << BIT_POS;
        w_sden  = CW'(i_hi) << BIT_POS;
        w_htake = HUE_ACT && (CW'(i_hrem) >= w_hden);
        w_stake = SAT_ACT && (CW'(i_srem) >= w_sden);
        n_hrem  = w_htake ? HNW'(CW'(i_hrem) - w_hden) : i_hrem;
        n_srem  = w_stake ? SNW'(CW'(i_srem) - w_sden) : i_srem;
        n_hquo  = i_hquo | (HQB'(w_htake) << BIT_POS);
        n_squo  = i_squo | (SQB'(w_stake) << BIT_POS);
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_hi   <= i_hi;
            r_d    <= i_d;
            r_hrem <= n_hrem;
            r_hquo <= n_hquo;
            r_srem <= n_srem;
            r_squo <= n_squo;
        end
    end

    assign o_valid = r_valid;
    assign o_hi    = r_hi;
    assign o_d     = r_d;
    assign o_hrem  = r_hrem;
    assign o_hquo  = r_hquo;
    assign o_srem  = r_srem;
    assign o_squo  = r_squo;

endmodule

// ===== src/rgb_to_hsv_converter.sv =====
// RGB to HSV converter top level: front end, divider pipeline, output register.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div_stage and the defines header.
//
// Usage:
// The slave channel (i_s_axis_*) takes one pixel per request; tdata holds red,
// green and blue from the lowest bits up. The master channel (o_m_axis_*)
// gives hue, saturation and brightness (value) per pixel, in the same order.
// Throughput is one pixel per clock while i_m_axis_tready is held high.
// Each accepted pixel passes through the two front-end stages, then the D
// divider stages, where D is the larger of (9 + HUE_FRAC_BITS) and
// (SAT_BITS + 1), each resolving one quotient bit of the hue, the saturation
// or both, and then the output register, which drives o_m_axis_tvalid.
// Every stage carries its own valid bit and moves when the stage after it is
// empty or moving, so bubbles close up and the input side keeps accepting
// while a finished result waits to be taken. When the receiver holds tready
// low, the pipeline fills and then o_s_axis_tready drops; nothing is lost or
// repeated. Reset clears all valid bits; the block has no other state.
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_BITS      = rgbhsv_pkg::SAT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // Fields from bit 0 up: red, green, blue.
    input  logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // Fields from bit 0 up: hue, saturation, brightness.
    output logic [((rgbhsv_pkg::HUE_INT_BITS + HUE_FRAC_BITS + SAT_BITS + CHANNEL_BITS + 7)
                   / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int C      = CHANNEL_BITS;
    localparam int HQB    = rgbhsv_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
    localparam int SQB    = SAT_BITS + 1;
    localparam int HNW    = C + HQB;
    localparam int SNW    = C + SAT_BITS;
    localparam int DS     = rgbhsv_pkg::div_stage_count(HUE_FRAC_BITS, SAT_BITS);
    localparam int OUT_W  = HQB + SAT_BITS + C;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int HUE_LIMIT = rgbhsv_pkg::HUE_FULL_DEG << HUE_FRAC_BITS;

    // Pipeline links; index 0 is the front end output, index DS the last step.
    logic           w_valid [0:DS];
    logic           w_ready [0:DS];
    logic [C-1:0]   w_hi    [0:DS];
    logic [C-1:0]   w_d     [0:DS];
    logic [HNW-1:0] w_hrem  [0:DS];
    logic [HQB-1:0] w_hquo  [0:DS];
    logic [SNW-1:0] w_srem  [0:DS];
    logic [SQB-1:0] w_squo  [0:DS];

    logic [C-1:0]        w_red;
    logic [C-1:0]        w_green;
    logic [C-1:0]        w_blue;
    logic                r_out_valid;
    logic [HQB-1:0]      r_out_hue;
    logic [SAT_BITS-1:0] r_out_sat;
    logic [C-1:0]        r_out_bright;
    logic [HQB-1:0]      n_out_hue;
    logic [SAT_BITS-1:0] n_out_sat;

    // Unpack the pixel.
    assign w_red   = i_s_axis_tdata[C-1:0];
    assign w_green = i_s_axis_tdata[2*C-1:C];
    assign w_blue  = i_s_axis_tdata[3*C-1:2*C];

    // Max/min, sector and dividends.
    rgbhsv_front #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SAT_BITS      (SAT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (w_red),
        .i_green (w_green),
        .i_blue  (w_blue),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_hi    (w_hi[0]),
        .o_d     (w_d[0]),
        .o_hrem  (w_hrem[0]),
        .o_srem  (w_srem[0])
    );

    // Both quotients start empty.
    assign w_hquo[0] = '0;
    assign w_squo[0] = '0;

    // Divider pipeline, most significant quotient bit first.
    for (genvar k = 0; k < DS; k++) begin : g_div
        rgbhsv_div_stage #(
            .CHANNEL_BITS  (CHANNEL_BITS),
            .HUE_FRAC_BITS (HUE_FRAC_BITS),
            .SAT_BITS      (SAT_BITS),
            .BIT_POS       (DS - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_hi    (w_hi[k]),
            .i_d     (w_d[k]),
            .i_hrem  (w_hrem[k]),
            .i_hquo  (w_hquo[k]),
            .i_srem  (w_srem[k]),
            .i_squo  (w_squo[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_hi    (w_hi[k+1]),
            .o_d     (w_d[k+1]),
            .o_hrem  (w_hrem[k+1]),
            .o_hquo  (w_hquo[k+1]),
            .o_srem  (w_srem[k+1]),
            .o_squo  (w_squo[k+1])
        );
    end

    // Output register takes a request when empty or when the receiver takes one.
    assign w_ready[DS] = !r_out_valid || i_m_axis_tready;

    // Grey pixels get hue 0, black pixels saturation 0, and a full
    // saturation quotient clamps to the largest code.
    always_comb begin
        n_out_hue = (w_d[DS] == '0) ? '0 : w_hquo[DS];
        if (w_hi[DS] == '0) begin
            n_out_sat = '0;
        end else if (w_squo[DS][SAT_BITS]) begin
            n_out_sat = '1;
        end else begin
            n_out_sat = w_squo[DS][SAT_BITS-1:0];
        end
    end

    // Output valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[DS]) begin
            r_out_valid <= w_valid[DS];
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_ready[DS]) begin
            r_out_hue    <= n_out_hue;
            r_out_sat    <= n_out_sat;
            r_out_bright <= w_hi[DS];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TW'({r_out_bright, r_out_sat, r_out_hue});

    // Hue always stays below a full turn.
    `RGBHSV_CHECK(a_hue_range, r_out_valid, r_out_hue < HQB'(HUE_LIMIT), "hue out of range")

    // A black pixel has neither hue nor saturation.
    `RGBHSV_CHECK(a_black_pixel, r_out_valid && (r_out_bright == '0),
        (r_out_sat == '0) && (r_out_hue == '0), "black pixel has hue or saturation")

    // After the last step both remainders are below their divisors.
    `RGBHSV_CHECK(a_rem_bound, w_valid[DS] && (w_d[DS] != '0),
        (w_hrem[DS] < HNW'(w_d[DS])) && (w_srem[DS] < SNW'(w_hi[DS])),
        "divider remainder not reduced")

    // A result leaving the divider lands in the output register.
    `RGBHSV_CHECK_NEXT(a_out_load, w_valid[DS] && w_ready[DS], r_out_valid,
        "result lost at output register")

endmodule
